### sv/mwm_pkg.sv
//------------------------------------------------------------------------------
// mwm_pkg
// Shared constants, types and the CORDIC arctangent table of the wheel mixer.
//------------------------------------------------------------------------------
`default_nettype none
package mwm_pkg;

  localparam int CordicStagesDefault = 16;
  localparam int CordicStagesMax     = 24;
  localparam int GuardBits           = 8;
  localparam logic signed [31:0] GainQ30 = 32'sd652032874;

  // Register byte addresses
  localparam logic [1:0] AddrFieldOriented = 2'd0;

  // CORDIC vector width: Q1.15 plus guard bits plus growth
  localparam int VecW = 28;
  localparam int AngW = 33;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [AngW-1:0] ang_t;

  // Arctangent of 2^-i, 2^32 = full turn, rounded to nearest
  function automatic ang_t atan_lut(input logic [4:0] i);
    ang_t a;
    case (i)
      5'd0:  a = 33'sd536870912;
      5'd1:  a = 33'sd316933406;
      5'd2:  a = 33'sd167458907;
      5'd3:  a = 33'sd85004756;
      5'd4:  a = 33'sd42667331;
      5'd5:  a = 33'sd21354465;
      5'd6:  a = 33'sd10679838;
      5'd7:  a = 33'sd5340245;
      5'd8:  a = 33'sd2670163;
      5'd9:  a = 33'sd1335087;
      5'd10: a = 33'sd667544;
      5'd11: a = 33'sd333772;
      5'd12: a = 33'sd166886;
      5'd13: a = 33'sd83443;
      5'd14: a = 33'sd41721;
      5'd15: a = 33'sd20861;
      5'd16: a = 33'sd10430;
      5'd17: a = 33'sd5215;
      5'd18: a = 33'sd2608;
      5'd19: a = 33'sd1304;
      5'd20: a = 33'sd652;
      5'd21: a = 33'sd326;
      5'd22: a = 33'sd163;
      5'd23: a = 33'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

### sv/mecanum_wheel_mixer.sv
//------------------------------------------------------------------------------
// mecanum_wheel_mixer
// Field-oriented mecanum drive mixer: CORDIC rotation, vector magnitude,
// wheel mix and proportional scaling, fully pipelined.
//------------------------------------------------------------------------------
// Channel  | Direction | Signals
// command  | in/out    | start, busy, strafe_cmd, forward_cmd, rotate_cmd, heading
// wheels   | out       | done, left_front, left_rear, right_front, right_rear
// config   | in/out    | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One transaction per cycle; busy is always low.
// Results pass through the CORDIC and gain stages, the squares, the square root,
// then the mix, max, divider and output stages.
// Synchronous reset clears field_oriented and all valid bits.
// The receiver cannot stall; done pulses for one cycle per result.
//------------------------------------------------------------------------------
`default_nettype none
module mecanum_wheel_mixer
  import mwm_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] strafe_cmd,
  input  wire logic signed [15:0] forward_cmd,
  input  wire logic signed [15:0] rotate_cmd,
  input  wire logic        [15:0] heading,
  output logic                    done,
  output logic signed [16:0]      left_front,
  output logic signed [16:0]      left_rear,
  output logic signed [16:0]      right_front,
  output logic signed [16:0]      right_rear,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [1:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic field_oriented;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Register write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      field_oriented <= 1'b0;
    end else if (psel && penable && pwrite && paddr == AddrFieldOriented) begin
      field_oriented <= pwdata[0];
    end
  end
  assign prdata = (paddr == AddrFieldOriented) ? {31'd0, field_oriented} : 32'd0;

  // Rotation
  logic               c_v;
  logic signed [16:0] c_x;
  logic signed [16:0] c_y;
  logic signed [15:0] c_r;

  mwm_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .enable    (field_oriented),
    .in_x      (strafe_cmd),
    .in_y      (forward_cmd),
    .in_r      (rotate_cmd),
    .in_h      (heading),
    .out_valid (c_v),
    .out_x     (c_x),
    .out_y     (c_y),
    .out_r     (c_r)
  );

  // Sum of squares
  logic               q_v;
  logic [33:0]        q_s;
  logic signed [16:0] q_x;
  logic signed [16:0] q_y;
  logic signed [15:0] q_r;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else begin
      q_v <= c_v;
    end
    q_s <= (34'(c_x) * 34'(c_x)) + (34'(c_y) * 34'(c_y));
    q_x <= c_x;
    q_y <= c_y;
    q_r <= c_r;
  end

  // Magnitude
  localparam int SideW = 50;
  logic             s_v;
  logic [16:0]      s_mag;
  logic [SideW-1:0] s_side;

  mwm_sqrt #(.SIDE_W(SideW)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_v),
    .in_v      (q_s),
    .in_side   ({q_x, q_y, q_r}),
    .out_valid (s_v),
    .out_root  (s_mag),
    .out_side  (s_side)
  );

  // Mix and scale
  logic signed [16:0] w [4];

  mwm_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_v),
    .in_x      (s_side[49:33]),
    .in_y      (s_side[32:16]),
    .in_r      (s_side[15:0]),
    .in_mag    (s_mag),
    .out_valid (done),
    .out_w     (w)
  );

  assign left_front  = w[0];
  assign left_rear   = w[1];
  assign right_front = w[2];
  assign right_rear  = w[3];

endmodule
`default_nettype wire

### sv/mwm_cordic.sv
//------------------------------------------------------------------------------
// mwm_cordic
// Pipelined CORDIC rotation of (x, y) by a binary angle, with gain correction.
//------------------------------------------------------------------------------
`default_nettype none
module mwm_cordic
  import mwm_pkg::*;
#(
  parameter int CORDIC_STAGES = CordicStagesDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               enable,
  input  wire logic signed [15:0] in_x,
  input  wire logic signed [15:0] in_y,
  input  wire logic signed [15:0] in_r,
  input  wire logic        [15:0] in_h,
  output logic                    out_valid,
  output logic signed [16:0]      out_x,
  output logic signed [16:0]      out_y,
  output logic signed [15:0]      out_r
);

  localparam int N = (CORDIC_STAGES > CordicStagesMax) ? CordicStagesMax : CORDIC_STAGES;

  logic              vld [N+1];
  logic              en  [N+1];
  vec_t              xs  [N+1];
  vec_t              ys  [N+1];
  ang_t              zs  [N+1];
  logic signed [15:0] rs [N+1];
  logic signed [16:0] px [N+1];
  logic signed [16:0] py [N+1];

  // Fold heading into [-90, +90] degrees
  logic signed [16:0] zq;
  logic signed [16:0] zf;
  logic               flip;
  vec_t               x0;
  vec_t               y0;

  always_comb begin
    zq   = {in_h[15], in_h};
    flip = (zq > 17'sd16384) || (zq < -17'sd16384);
    zf   = zq;
    if (zq > 17'sd16384) begin
      zf = zq - 17'sd32768;
    end else if (zq < -17'sd16384) begin
      zf = zq + 17'sd32768;
    end
    x0 = vec_t'(in_x) <<< GuardBits;
    y0 = vec_t'(in_y) <<< GuardBits;
    if (flip) begin
      x0 = -x0;
      y0 = -y0;
    end
  end

  // Stage 0 register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    en[0] <= enable;
    xs[0] <= x0;
    ys[0] <= y0;
    zs[0] <= ang_t'(zf) <<< 16;
    rs[0] <= in_r;
    px[0] <= 17'(in_x);
    py[0] <= 17'(in_y);
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    vec_t dx;
    vec_t dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      en[i+1] <= en[i];
      rs[i+1] <= rs[i];
      px[i+1] <= px[i];
      py[i+1] <= py[i];
      if (!zs[i][AngW-1]) begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - atan_lut(5'(i));
      end else begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + atan_lut(5'(i));
      end
    end
  end

  // Gain multiply stage
  logic signed [59:0] gx;
  logic signed [59:0] gy;
  logic               gv;
  logic               gen;
  logic signed [15:0] gr;
  logic signed [16:0] gpx;
  logic signed [16:0] gpy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gv <= 1'b0;
    end else begin
      gv <= vld[N];
    end
    gen <= en[N];
    gr  <= rs[N];
    gpx <= px[N];
    gpy <= py[N];
    gx  <= 60'(xs[N]) * 60'(GainQ30);
    gy  <= 60'(ys[N]) * 60'(GainQ30);
  end

  // Round half up and drop guard and gain fraction
  logic signed [59:0] rx;
  logic signed [59:0] ry;
  assign rx = (gx + (60'sd1 <<< 37)) >>> 38;
  assign ry = (gy + (60'sd1 <<< 37)) >>> 38;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= gv;
    end
    out_r <= gr;
    out_x <= gen ? rx[16:0] : gpx;
    out_y <= gen ? ry[16:0] : gpy;
  end

endmodule
`default_nettype wire

### sv/mwm_sqrt.sv
//------------------------------------------------------------------------------
// mwm_sqrt
// Pipelined floor integer square root, one result bit per stage.
//------------------------------------------------------------------------------
`default_nettype none
module mwm_sqrt
  import mwm_pkg::*;
#(
  parameter int SIDE_W = 68
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic [33:0]       in_v,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [16:0]            out_root,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int B = 17;

  logic              vld  [B+1];
  logic [33:0]       rem  [B+1];
  logic [16:0]       root [B+1];
  logic [SIDE_W-1:0] side [B+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_v;
  assign root[0] = '0;
  assign side[0] = in_side;

  // Bit-by-bit square root by trial squaring, MSB first
  for (genvar i = 0; i < B; i++) begin : g_bit
    localparam int K = B - 1 - i;
    logic [33:0] trial;
    logic [33:0] cand;
    assign cand  = {17'd0, root[i] | (17'd1 << K)};
    assign trial = cand * cand;
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1]  <= rem[i];
      side[i+1] <= side[i];
      root[i+1] <= (trial <= rem[i]) ? cand[16:0] : root[i];
    end
  end

  assign out_valid = vld[B];
  assign out_root  = root[B];
  assign out_side  = side[B];

endmodule
`default_nettype wire

### sv/mwm_scale.sv
//------------------------------------------------------------------------------
// mwm_scale
// Mixes the wheels, finds the largest magnitude and, when it exceeds 32768,
// scales by mag / maxabs with a pipelined restoring divider.
//------------------------------------------------------------------------------
`default_nettype none
module mwm_scale
  import mwm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [16:0] in_x,
  input  wire logic signed [16:0] in_y,
  input  wire logic signed [15:0] in_r,
  input  wire logic        [16:0] in_mag,
  output logic                    out_valid,
  output logic signed [16:0]      out_w [4]
);

  // Mix and magnitudes
  logic signed [18:0] w_c [4];
  logic        [17:0] a_c [4];
  always_comb begin
    w_c[0] = 19'(in_y) + 19'(in_r) + 19'(in_x);
    w_c[1] = 19'(in_y) + 19'(in_r) - 19'(in_x);
    w_c[2] = -19'(in_y) + 19'(in_r) + 19'(in_x);
    w_c[3] = -19'(in_y) + 19'(in_r) - 19'(in_x);
    for (int k = 0; k < 4; k++) begin
      a_c[k] = w_c[k][18] ? 18'(-w_c[k]) : w_c[k][17:0];
    end
  end

  logic               s1_v;
  logic signed [18:0] s1_w [4];
  logic        [17:0] s1_a [4];
  logic        [16:0] s1_mag;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
    end
    s1_w   <= w_c;
    s1_a   <= a_c;
    s1_mag <= in_mag;
  end

  // Max of four magnitudes, products by mag
  logic [17:0] m01;
  logic [17:0] m23;
  logic [17:0] mx;
  assign m01 = (s1_a[1] > s1_a[0]) ? s1_a[1] : s1_a[0];
  assign m23 = (s1_a[3] > s1_a[2]) ? s1_a[3] : s1_a[2];
  assign mx  = (m23 > m01) ? m23 : m01;

  logic               s2_v;
  logic               s2_sc;
  logic [17:0]        s2_max;
  logic signed [18:0] s2_w [4];
  logic [34:0]        s2_p [4];
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_sc  <= mx > 18'd32768;
    s2_max <= mx;
    s2_w   <= s1_w;
    for (int k = 0; k < 4; k++) begin
      s2_p[k] <= 35'(s1_a[k]) * 35'(s1_mag);
    end
  end

  // Restoring division, one quotient bit per stage per wheel
  localparam int QB = 17;
  logic        dv   [QB+1];
  logic        dsc  [QB+1];
  logic [17:0] dden [QB+1];
  logic        dneg [QB+1][4];
  logic [16:0] dq   [QB+1][4];
  logic [34:0] dnum [QB+1][4];
  logic signed [18:0] dw [QB+1][4];

  always_comb begin
    dv[0]   = s2_v;
    dsc[0]  = s2_sc;
    dden[0] = s2_max;
    for (int k = 0; k < 4; k++) begin
      dneg[0][k] = s2_w[k][18];
      dq[0][k]   = '0;
      dnum[0][k] = s2_p[k];
      dw[0][k]   = s2_w[k];
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    localparam int K = QB - 1 - i;
    // Quotient below 2^17 because product over maxabs is at most mag
    logic [35:0] trial [4];
    always_comb begin
      for (int k = 0; k < 4; k++) begin
        trial[k] = {1'b0, dnum[i][k]} - ({18'd0, dden[i]} << K);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else begin
        dv[i+1] <= dv[i];
      end
      dsc[i+1]  <= dsc[i];
      dden[i+1] <= dden[i];
      for (int k = 0; k < 4; k++) begin
        dneg[i+1][k] <= dneg[i][k];
        dw[i+1][k]   <= dw[i][k];
        if (!trial[k][35]) begin
          dnum[i+1][k] <= trial[k][34:0];
          dq[i+1][k]   <= dq[i][k] | (17'd1 << K);
        end else begin
          dnum[i+1][k] <= dnum[i][k];
          dq[i+1][k]   <= dq[i][k];
        end
      end
    end
  end

  // Apply sign, select scaled or plain value
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv[QB];
    end
    for (int k = 0; k < 4; k++) begin
      if (dsc[QB]) begin
        out_w[k] <= dneg[QB][k] ? -dq[QB][k] : dq[QB][k];
      end else begin
        out_w[k] <= dw[QB][k][16:0];
      end
    end
  end

endmodule
`default_nettype wire
